FILE: design/lis_pkg.sv
// Shared constants and types for the longest increasing subsequence block.
// No dependencies; every other design file imports this package.
package lis_pkg;

  // Default configuration of the block
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Fixed widths of the result side-band fields
  localparam int SEQ_LEN_W = 7;
  localparam int USER_W    = SEQ_LEN_W + 1;

  // Report of a search token settling in one cell of the tail chain
  typedef struct packed {
    logic hit;      // token settled this cycle
    logic changed;  // tail was replaced (value not equal to the old tail)
    logic extend;   // cell was empty: run length grows by one
    logic at_top;   // cell holds the longest run's tail
  } lis_land_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_TSTART,
    ST_TRD,
    ST_TWR,
    ST_ERD,
    ST_ELD
  } lis_state_t;

endpackage

FILE: design/lis_cell.sv
// One cell of the tail chain: holds the smallest tail for one run length.
// Depends on lis_pkg.
module lis_cell #(
  parameter int MAX_ELEMENTS = 64,
  parameter int VALUE_WIDTH  = 32,
  parameter bit IS_FIRST     = 1'b0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 next_valid,
  input  logic                                 in_act,
  input  logic signed [VALUE_WIDTH-1:0]        in_value,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]      in_idx,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]      in_prev,
  output logic                                 valid,
  output logic                                 out_act,
  output logic signed [VALUE_WIDTH-1:0]        out_value,
  output logic [$clog2(MAX_ELEMENTS)-1:0]      out_idx,
  output logic [$clog2(MAX_ELEMENTS)-1:0]      out_prev,
  output lis_pkg::lis_land_t                   land,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0]    link
);
  import lis_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int LINK_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_ELEMENTS);

  logic signed [VALUE_WIDTH-1:0] tail;
  logic [IDX_W-1:0]              pos;
  logic                          lt;
  logic                          eq;
  logic                          settle;
  logic                          change;

  // Settle at the first tail that is not smaller, or at the first empty cell
  always_comb begin
    lt     = tail < in_value;
    eq     = tail == in_value;
    settle = in_act && (!valid || !lt);
    change = settle && !(valid && eq);
    land.hit     = settle;
    land.changed = change;
    land.extend  = settle && !valid;
    land.at_top  = !valid || !next_valid;
    if (change && !IS_FIRST) begin
      link = LINK_W'(in_prev);
    end else begin
      link = NO_LINK;
    end
  end

  // Hold the tail; pass an unsettled token on to the next cell
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= 1'b0;
      out_act <= 1'b0;
    end else begin
      out_act <= in_act && !settle;
      if (change) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_value <= in_value;
    out_idx   <= in_idx;
    out_prev  <= pos;
    if (change) begin
      tail <= in_value;
      pos  <= in_idx;
    end
  end

endmodule

FILE: design/lis_chain.sv
// Row of tail cells, the search token stepping one cell per cycle.
// Depends on lis_pkg and lis_cell.
module lis_chain #(
  parameter int MAX_ELEMENTS = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 tok_act,
  input  logic signed [VALUE_WIDTH-1:0]        tok_value,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]      tok_idx,
  output lis_pkg::lis_land_t                   land,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0]    land_link
);
  import lis_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int LINK_W = $clog2(MAX_ELEMENTS + 1);

  logic                          act   [0:MAX_ELEMENTS];
  logic signed [VALUE_WIDTH-1:0] value [0:MAX_ELEMENTS];
  logic [IDX_W-1:0]              idx   [0:MAX_ELEMENTS];
  logic [IDX_W-1:0]              prev  [0:MAX_ELEMENTS];
  logic                          cvalid[0:MAX_ELEMENTS];
  lis_land_t                     cland [0:MAX_ELEMENTS-1];
  logic [LINK_W-1:0]             clink [0:MAX_ELEMENTS-1];

  // Feed the token into the head of the row
  assign act[0]   = tok_act;
  assign value[0] = tok_value;
  assign idx[0]   = tok_idx;
  assign prev[0]  = '0;
  assign cvalid[MAX_ELEMENTS] = 1'b0;

  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    lis_cell #(
      .MAX_ELEMENTS(MAX_ELEMENTS),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IS_FIRST    (i == 0)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear),
      .next_valid(cvalid[i+1]),
      .in_act    (act[i]),
      .in_value  (value[i]),
      .in_idx    (idx[i]),
      .in_prev   (prev[i]),
      .valid     (cvalid[i]),
      .out_act   (act[i+1]),
      .out_value (value[i+1]),
      .out_idx   (idx[i+1]),
      .out_prev  (prev[i+1]),
      .land      (cland[i]),
      .link      (clink[i])
    );
  end

  // Merge the reports; at most one cell holds the token in a cycle
  always_comb begin
    land      = '0;
    land_link = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (cland[i].hit) begin
        land      = land | cland[i];
        land_link = land_link | clink[i];
      end
    end
  end

endmodule

FILE: design/longest_increasing_subsequence.sv
// Top level of the longest strictly increasing subsequence block.
// Depends on lis_pkg and lis_chain (which instantiates lis_cell).
//
// Input stream: s_axis_tdata carries one signed element, s_axis_tlast marks
// the last element of a sequence. Output stream: one item per member of the
// longest strictly increasing subsequence, in ascending order, given only
// after the last element; m_axis_tlast marks the final member.
// An element is placed by a token that walks the chain of tail cells, one
// cell per cycle; no new element is accepted until the token has settled in
// a cell, while a dropped element is not searched. After the last element
// the back-links are walked through the element memory (ST_TSTART, then
// ST_TRD and ST_TWR per member) and the members are then delivered one by
// one (ST_ERD, then ST_ELD, which waits while the receiver does not keep up).
// Elements past MAX_ELEMENTS are dropped and the overflowed flag is set.
// A sequence with no stored element produces no output item.
// The output register holds its item while m_axis_tready is low; the
// sequencer waits, and no new element is taken until the last member is in
// the output register. Reset empties the chain and clears the counters and
// the overflow flag; the element memories need no clearing, as only entries
// of the current sequence are ever read.
module longest_increasing_subsequence #(
  parameter int MAX_ELEMENTS = lis_pkg::MAX_ELEMENTS_DEF,
  parameter int VALUE_WIDTH  = lis_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // value[VALUE_WIDTH-1:0], zero padding above
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                  s_axis_tlast,   // final_element
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // element[VALUE_WIDTH-1:0], zero padding above
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]      m_axis_tdata,
  // sequence_length[6:0], overflowed[7]
  output logic [lis_pkg::USER_W-1:0]            m_axis_tuser,
  output logic                                  m_axis_tlast    // last_of_run
);
  import lis_pkg::*;

  localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int LINK_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int LEN_W   = $clog2(MAX_ELEMENTS + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ELEMENTS);

  lis_state_t state, state_next;

  logic [LEN_W-1:0]              count;
  logic [LEN_W-1:0]              len;
  logic                          ovf;
  logic                          fin_q;
  logic [IDX_W-1:0]              cur_idx;
  logic [IDX_W-1:0]              last_pos;
  logic [IDX_W-1:0]              pos;
  logic [IDX_W-1:0]              k;
  logic [IDX_W-1:0]              r;

  logic                          tok_act;
  logic signed [VALUE_WIDTH-1:0] tok_value;
  lis_land_t                     land;
  logic [LINK_W-1:0]             land_link;

  logic [VALUE_WIDTH-1:0]        stored_mem [0:MAX_ELEMENTS-1];
  logic [LINK_W-1:0]             link_mem   [0:MAX_ELEMENTS-1];
  logic [VALUE_WIDTH-1:0]        buf_mem    [0:MAX_ELEMENTS-1];
  logic [VALUE_WIDTH-1:0]        stored_rd;
  logic [LINK_W-1:0]             link_rd;
  logic [VALUE_WIDTH-1:0]        buf_rd;

  logic accept;
  logic full;
  logic out_free;
  logic last_r;
  logic inject;
  logic finish;
  logic load_out;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign full     = count == LEN_MAX;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign last_r   = LEN_W'(r) == len - LEN_W'(1);

  lis_chain #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_chain (
    .clk      (clk),
    .rst      (rst),
    .clear    (finish),
    .tok_act  (tok_act),
    .tok_value(tok_value),
    .tok_idx  (cur_idx),
    .land     (land),
    .land_link(land_link)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!full) begin
            state_next = ST_SEARCH;
          end else if (s_axis_tlast && len != '0) begin
            state_next = ST_TSTART;
          end
        end
      end
      ST_SEARCH: begin
        if (land.hit) begin
          state_next = fin_q ? ST_TSTART : ST_IDLE;
        end
      end
      ST_TSTART: state_next = ST_TRD;
      ST_TRD:    state_next = ST_TWR;
      ST_TWR:    state_next = (k == '0) ? ST_ERD : ST_TRD;
      ST_ERD:    state_next = ST_ELD;
      ST_ELD: begin
        if (out_free) begin
          state_next = last_r ? ST_IDLE : ST_ERD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    inject        = 1'b0;
    finish        = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        inject        = s_axis_tvalid && !full;
        finish        = s_axis_tvalid && full && s_axis_tlast && len == '0;
      end
      ST_ELD: begin
        load_out = out_free;
        finish   = out_free && last_r;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters, flags and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      len           <= '0;
      ovf           <= 1'b0;
      tok_act       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      tok_act <= inject;
      if (inject) begin
        count <= count + LEN_W'(1);
      end
      if (accept && full) begin
        ovf <= 1'b1;
      end
      if (land.hit && land.extend) begin
        len <= len + LEN_W'(1);
      end
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (finish) begin
        count <= '0;
        len   <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // Token payload, walk pointers and the output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fin_q <= s_axis_tlast;
    end
    if (inject) begin
      tok_value <= s_axis_tdata[VALUE_WIDTH-1:0];
      cur_idx   <= count[IDX_W-1:0];
    end
    if (land.hit && land.changed && land.at_top) begin
      last_pos <= cur_idx;
    end
    case (state)
      ST_TSTART: begin
        pos <= last_pos;
        k   <= IDX_W'(len - LEN_W'(1));
      end
      ST_TWR: begin
        pos <= link_rd[IDX_W-1:0];
        k   <= k - IDX_W'(1);
        r   <= '0;
      end
      ST_ELD: begin
        if (out_free) begin
          r <= r + IDX_W'(1);
        end
      end
      default: begin
        r <= r;
      end
    endcase
    if (load_out) begin
      m_axis_tdata <= TDATA_W'(buf_rd);
      m_axis_tuser <= {ovf, SEQ_LEN_W'(len)};
      m_axis_tlast <= last_r;
    end
  end

  // Element store and back-links
  always_ff @(posedge clk) begin
    if (inject) begin
      stored_mem[count[IDX_W-1:0]] <= s_axis_tdata[VALUE_WIDTH-1:0];
    end
    if (land.hit) begin
      link_mem[cur_idx] <= land_link;
    end
    stored_rd <= stored_mem[pos];
    link_rd   <= link_mem[pos];
  end

  // Reorder buffer: filled from the longest tail backward, read ascending
  always_ff @(posedge clk) begin
    if (state == ST_TWR) begin
      buf_mem[k] <= stored_rd;
    end
    buf_rd <= buf_mem[r];
  end

endmodule
